### hw/rtl/sax_symbolizer_unit_defines.svh
// Assertion macros used by the checker file of the symbolizer.
`ifndef SAX_SYMBOLIZER_UNIT_DEFINES_SVH
`define SAX_SYMBOLIZER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sax_symbolizer_unit: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SAX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sax_symbolizer_unit: assertion failed");

`endif

### hw/rtl/sax_pkg.sv
// Types, constants and the breakpoint table of the SAX symbolizer.
`default_nettype none

package sax_pkg;

   localparam int unsigned MAX_SERIES_LENGTH_DEF = 4096;
   localparam int unsigned MAX_SEGMENTS_DEF      = 256;
   localparam int unsigned FRAC_BITS_DEF         = 12;

   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned SYMBOL_W     = 4;
   localparam int unsigned SEG_INDEX_W  = 8;
   localparam int unsigned ALPHA_W      = 4;
   localparam int unsigned SEG_COUNT_W  = 9;
   localparam int unsigned SERIES_LEN_W = 13;
   localparam int unsigned CSR_DATA_W   = 13;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned BP_W         = 8;
   localparam int unsigned BP_COL_W     = 3;

   localparam int unsigned ALPHA_RESET      = 4;
   localparam int unsigned SEG_COUNT_RESET  = 8;
   localparam int unsigned SERIES_LEN_RESET = 128;
   localparam int unsigned ALPHA_MIN        = 2;
   localparam int unsigned ALPHA_MAX        = 9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALPHABET_SIZE = 2'd0,
      CSR_SEGMENT_COUNT = 2'd1,
      CSR_SERIES_LENGTH = 2'd2
   } sax_csr_type;

   typedef enum logic [2:0] {
      ST_START,
      ST_DIV,
      ST_IDLE,
      ST_CMP,
      ST_EMIT
   } sax_state_type;

   // Normal-quantile breakpoints in hundredths; row is alphabet size minus two.
   localparam logic signed [BP_W-1:0] BP_TABLE [0:7][0:7] = '{
      '{ 8'sd0,    8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0   },
      '{-8'sd43,   8'sd43,  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0   },
      '{-8'sd67,   8'sd0,   8'sd67,  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0   },
      '{-8'sd84,  -8'sd25,  8'sd25,  8'sd84,  8'sd0,   8'sd0,   8'sd0,   8'sd0   },
      '{-8'sd97,  -8'sd43,  8'sd0,   8'sd43,  8'sd97,  8'sd0,   8'sd0,   8'sd0   },
      '{-8'sd107, -8'sd57, -8'sd18,  8'sd18,  8'sd57,  8'sd107, 8'sd0,   8'sd0   },
      '{-8'sd115, -8'sd67, -8'sd32,  8'sd0,   8'sd32,  8'sd67,  8'sd115, 8'sd0   },
      '{-8'sd122, -8'sd76, -8'sd43, -8'sd14,  8'sd14,  8'sd43,  8'sd76,  8'sd122 }
   };

endpackage

`default_nettype wire

### hw/rtl/sax_req_if.sv
// Sample channel of the SAX symbolizer.
`default_nettype none

interface sax_req_if import sax_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/sax_rsp_if.sv
// Symbol channel of the SAX symbolizer.
`default_nettype none

interface sax_rsp_if import sax_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [SYMBOL_W-1:0]    symbol;
   logic [SEG_INDEX_W-1:0] segment_index;
   logic                   last;

   modport source (output valid, output symbol, output segment_index, output last,
                   input ready);
   modport sink   (input valid, input symbol, input segment_index, input last,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/sax_symbolizer_unit.sv
// Top level of the SAX symbolizer: segment accumulator, breakpoint compare and divider.
// A sample that does not close a segment leaves the block ready for the next. A sample
// that closes a segment is followed by a compare against each breakpoint of the effective
// alphabet (2 to 9 symbols) on the one shared multiplier, a load of the output register
// (held off while the previous symbol is still held), and then the shift-subtract divider
// runs one quotient bit a cycle to find the next segment length. After the final segment
// of a series the START state reloads the series before the divider runs. After reset and
// after every write to segment_count or series_length the block starts a new series and
// is not ready until the divider has found the first segment length. A finished symbol
// waits in the output register while the next segment's samples are taken.
`default_nettype none

module sax_symbolizer_unit import sax_pkg::*; #(
   parameter int unsigned MAX_SERIES_LENGTH = MAX_SERIES_LENGTH_DEF,
   parameter int unsigned MAX_SEGMENTS      = MAX_SEGMENTS_DEF,
   parameter int unsigned FRAC_BITS         = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   sax_req_if.sink                req_bus,
   sax_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned LEN_W   = $clog2(MAX_SERIES_LENGTH + 1);
   localparam int unsigned SEG_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned POS_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int unsigned SUM_W   = SAMPLE_W + LEN_W;
   localparam int unsigned RHS_W   = SUM_W + 7;
   localparam int unsigned PROD_W  = BP_W + LEN_W + 1;
   localparam int unsigned CMP_W   =
      ((RHS_W > PROD_W + FRAC_BITS) ? RHS_W : PROD_W + FRAC_BITS) + 1;
   localparam int unsigned DSTEP_W = $clog2(LEN_W + 1);

   sax_state_type state_ff, state_in;

   logic [ALPHA_W-1:0]      alphabet_ff;
   logic [SEG_COUNT_W-1:0]  seg_count_cfg_ff;
   logic [SERIES_LEN_W-1:0] series_len_cfg_ff;

   logic signed [SUM_W-1:0] sum_ff;
   logic [LEN_W-1:0]        in_seg_ff;
   logic [LEN_W-1:0]        seg_len_ff;
   logic [LEN_W-1:0]        remaining_ff;
   logic [SEG_W-1:0]        segs_left_ff;
   logic [POS_W-1:0]        pos_ff;

   logic [LEN_W-1:0]        div_num_ff;
   logic [SEG_W-1:0]        div_rem_ff;
   logic [DSTEP_W-1:0]      div_step_ff;

   logic [ALPHA_W-1:0]       bp_idx_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [RHS_W-1:0]  rhs_ff;
   logic [SYMBOL_W-1:0]      sym_ff;

   logic                   rsp_valid_ff;
   logic [SYMBOL_W-1:0]    rsp_symbol_ff;
   logic [SEG_INDEX_W-1:0] rsp_index_ff;
   logic                   rsp_last_ff;

   logic [31:0]        series_wide, count_wide, len_eff_wide, cnt_eff_wide;
   logic [LEN_W-1:0]   eff_len;
   logic [SEG_W-1:0]   eff_cnt;
   logic [ALPHA_W-1:0] alpha_eff, bp_count;
   logic               cfg_restart, seg_done, is_last, out_free, div_last;
   logic               load_series, accept, emit;
   logic [LEN_W-1:0]   remaining_next;

   logic [SEG_W:0]           div_trial;
   logic                     div_ge;
   logic [SEG_W-1:0]         rem_next;
   logic [LEN_W-1:0]         num_next;
   logic signed [BP_W-1:0]   bp_cur;
   logic signed [PROD_W-1:0] bp_ext, len_ext, prod_in;
   logic signed [RHS_W-1:0]  sum_wide, rhs_in;
   logic signed [CMP_W-1:0]  lhs_cmp, rhs_cmp;
   logic                     bp_hit;

   always_comb begin
      series_wide  = 32'(series_len_cfg_ff);
      count_wide   = 32'(seg_count_cfg_ff);
      len_eff_wide = series_wide;
      if (len_eff_wide == 32'd0) begin
         len_eff_wide = 32'd1;
      end
      if (len_eff_wide > 32'(MAX_SERIES_LENGTH)) begin
         len_eff_wide = 32'(MAX_SERIES_LENGTH);
      end
      cnt_eff_wide = count_wide;
      if (cnt_eff_wide == 32'd0) begin
         cnt_eff_wide = 32'd1;
      end
      if (cnt_eff_wide > 32'(MAX_SEGMENTS)) begin
         cnt_eff_wide = 32'(MAX_SEGMENTS);
      end
      if (cnt_eff_wide > len_eff_wide) begin
         cnt_eff_wide = len_eff_wide;
      end
      eff_len = LEN_W'(len_eff_wide);
      eff_cnt = SEG_W'(cnt_eff_wide);
   end

   always_comb begin
      if (alphabet_ff < ALPHA_W'(ALPHA_MIN)) begin
         alpha_eff = ALPHA_W'(ALPHA_MIN);
      end else if (alphabet_ff > ALPHA_W'(ALPHA_MAX)) begin
         alpha_eff = ALPHA_W'(ALPHA_MAX);
      end else begin
         alpha_eff = alphabet_ff;
      end
      bp_count = alpha_eff - ALPHA_W'(1);
   end

   assign cfg_restart    = csr_we && (csr_index == CSR_SEGMENT_COUNT ||
                                      csr_index == CSR_SERIES_LENGTH);
   assign seg_done       = ({1'b0, in_seg_ff} + (LEN_W + 1)'(1)) >= {1'b0, seg_len_ff};
   assign is_last        = segs_left_ff <= SEG_W'(1);
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign div_last       = div_step_ff == DSTEP_W'(LEN_W - 1);
   assign remaining_next = remaining_ff - seg_len_ff;

   // Restoring divider step, one quotient bit per cycle.
   assign div_trial = {div_rem_ff, div_num_ff[LEN_W-1]};
   assign div_ge    = div_trial >= {1'b0, segs_left_ff};
   assign rem_next  = div_ge ? SEG_W'(div_trial - {1'b0, segs_left_ff}) : SEG_W'(div_trial);
   assign num_next  = {div_num_ff[LEN_W-2:0], div_ge};

   // Shared breakpoint unit: bp * length, compared as (bp * length) << FRAC_BITS
   // against 100 * sum.
   assign bp_cur   = BP_TABLE[BP_COL_W'(alpha_eff - ALPHA_W'(ALPHA_MIN))][bp_idx_ff[BP_COL_W-1:0]];
   assign bp_ext   = PROD_W'(bp_cur);
   assign len_ext  = PROD_W'(seg_len_ff);
   assign prod_in  = bp_ext * len_ext;
   assign sum_wide = RHS_W'(sum_ff);
   assign rhs_in   = (sum_wide <<< 6) + (sum_wide <<< 5) + (sum_wide <<< 2);
   assign lhs_cmp  = CMP_W'(prod_ff) <<< FRAC_BITS;
   assign rhs_cmp  = CMP_W'(rhs_ff);
   assign bp_hit   = lhs_cmp <= rhs_cmp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      load_series = 1'b0;
      accept      = 1'b0;
      emit        = 1'b0;
      case (state_ff)
         ST_START: begin
            load_series = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               accept = 1'b1;
               if (seg_done) begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            if (bp_idx_ff == bp_count) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = is_last ? ST_START : ST_DIV;
            end
         end
         default: begin
            state_in = ST_START;
         end
      endcase
      if (cfg_restart) begin
         state_in = ST_START;
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff       <= ALPHA_W'(ALPHA_RESET);
         seg_count_cfg_ff  <= SEG_COUNT_W'(SEG_COUNT_RESET);
         series_len_cfg_ff <= SERIES_LEN_W'(SERIES_LEN_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHABET_SIZE: alphabet_ff       <= csr_wdata[ALPHA_W-1:0];
            CSR_SEGMENT_COUNT: seg_count_cfg_ff  <= csr_wdata[SEG_COUNT_W-1:0];
            CSR_SERIES_LENGTH: series_len_cfg_ff <= csr_wdata[SERIES_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_series) begin
         sum_ff       <= '0;
         in_seg_ff    <= '0;
         pos_ff       <= '0;
         remaining_ff <= eff_len;
         segs_left_ff <= eff_cnt;
         div_num_ff   <= eff_len;
         div_rem_ff   <= '0;
         div_step_ff  <= '0;
      end
      if (emit && !is_last) begin
         sum_ff       <= '0;
         in_seg_ff    <= '0;
         pos_ff       <= pos_ff + POS_W'(1);
         remaining_ff <= remaining_next;
         segs_left_ff <= segs_left_ff - SEG_W'(1);
         div_num_ff   <= remaining_next;
         div_rem_ff   <= '0;
         div_step_ff  <= '0;
      end
      if (state_ff == ST_DIV) begin
         div_num_ff  <= num_next;
         div_rem_ff  <= rem_next;
         div_step_ff <= div_step_ff + DSTEP_W'(1);
         if (div_last) begin
            seg_len_ff <= num_next;
         end
      end
      if (accept) begin
         sum_ff    <= sum_ff + SUM_W'(req_bus.sample);
         in_seg_ff <= in_seg_ff + LEN_W'(1);
         bp_idx_ff <= '0;
         sym_ff    <= '0;
      end
      if (state_ff == ST_CMP) begin
         bp_idx_ff <= bp_idx_ff + ALPHA_W'(1);
         prod_ff   <= prod_in;
         if (bp_idx_ff == '0) begin
            rhs_ff <= rhs_in;
         end else if (bp_hit) begin
            sym_ff <= sym_ff + SYMBOL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_symbol_ff <= sym_ff;
         rsp_index_ff  <= SEG_INDEX_W'(pos_ff);
         rsp_last_ff   <= is_last;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.symbol        = rsp_symbol_ff;
   assign rsp_bus.segment_index = rsp_index_ff;
   assign rsp_bus.last          = rsp_last_ff;

endmodule

`default_nettype wire

### hw/rtl/sax_symbolizer_checker.sv
// Port-level assertions for the SAX symbolizer and their bind to the top level.
`default_nettype none
`include "sax_symbolizer_unit_defines.svh"

module sax_symbolizer_checker import sax_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SYMBOL_W-1:0]    rsp_symbol,
   input wire logic [SEG_INDEX_W-1:0] rsp_segment_index,
   input wire logic                   rsp_last,
   input wire logic                   csr_we,
   input wire logic [CSR_INDEX_W-1:0] csr_index
);

   logic restart_write;
   logic rsp_stall;
   logic [SYMBOL_W+SEG_INDEX_W:0] rsp_payload;

   assign restart_write = csr_we && (csr_index == CSR_SEGMENT_COUNT ||
                                     csr_index == CSR_SERIES_LENGTH);
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_payload   = {rsp_symbol, rsp_segment_index, rsp_last};

   `SAX_ASSERT_NEXT(a_rsp_valid_held, clock, reset, rsp_stall, rsp_valid)

   `SAX_ASSERT_NEXT(a_rsp_payload_held, clock, reset, rsp_stall, $stable(rsp_payload))

   `SAX_ASSERT_NEXT(a_restart_blocks_input, clock, reset, restart_write, !req_ready)

   `SAX_ASSERT_SAME(a_not_ready_after_reset, clock, 1'b0, $fell(reset), !req_ready && !req_valid || !req_ready)

endmodule

bind sax_symbolizer_unit sax_symbolizer_checker u_sax_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_symbol        (rsp_bus.symbol),
   .rsp_segment_index (rsp_bus.segment_index),
   .rsp_last          (rsp_bus.last),
   .csr_we            (csr_we),
   .csr_index         (csr_index)
);

`default_nettype wire

### sim/tb_sax_symbolizer_unit.sv
// Self-checking testbench for sax_symbolizer_unit with a directed table and random series.
`timescale 1ns / 100ps

module tb_sax_symbolizer_unit;
   import sax_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 1030;
   localparam int STALL_AT      = 120;
   localparam int STALL_CYCLES  = 400;
   localparam int IDLE_PERCENT  = 25;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 2'd3;

   // Breakpoints in hundredths, one row per alphabet size starting at two.
   localparam bit [0:7][0:7][7:0] NORMAL_CUTS = {
      8'sd0,    8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,
      -8'sd43,  8'sd43,  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,
      -8'sd67,  8'sd0,   8'sd67,  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,
      -8'sd84,  -8'sd25, 8'sd25,  8'sd84,  8'sd0,   8'sd0,   8'sd0,   8'sd0,
      -8'sd97,  -8'sd43, 8'sd0,   8'sd43,  8'sd97,  8'sd0,   8'sd0,   8'sd0,
      -8'sd107, -8'sd57, -8'sd18, 8'sd18,  8'sd57,  8'sd107, 8'sd0,   8'sd0,
      -8'sd115, -8'sd67, -8'sd32, 8'sd0,   8'sd32,  8'sd67,  8'sd115, 8'sd0,
      -8'sd122, -8'sd76, -8'sd43, -8'sd14, 8'sd14,  8'sd43,  8'sd76,  8'sd122
   };

   typedef struct packed {
      logic [SYMBOL_W-1:0]    symbol;
      logic [SEG_INDEX_W-1:0] segment_index;
      logic                   last;
   } symbol_rec_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} probe_kind_type;

   typedef struct packed {
      probe_kind_type             kind;
      logic [CSR_INDEX_W-1:0]     csr;
      logic [CSR_DATA_W-1:0]      value;
      logic signed [SAMPLE_W-1:0] sample;
      bit                         typed;
      symbol_rec_type             want;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sax_req_if req_bus ();
   sax_rsp_if rsp_bus ();

   sax_symbolizer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   symbol_rec_type pending_symbols [$];
   probe_row_type  probe_rows [$];
   int failures = 0;
   int symbols_seen = 0;
   int cycle_count = 0;
   bit steady_stretch = 1'b0;
   bit long_stall_done = 1'b0;
   int sample_level = 0;

   logic [ALPHA_W-1:0]      cfg_alphabet;
   logic [SEG_COUNT_W-1:0]  cfg_segments;
   logic [SERIES_LEN_W-1:0] cfg_length;
   longint      seg_sum;
   int unsigned seg_fill;
   int unsigned seg_len;
   int unsigned samples_left;
   int unsigned segs_left;
   int unsigned seg_pos;

   function automatic void restart_series();
      int unsigned len;
      int unsigned cnt;
      len = cfg_length;
      cnt = cfg_segments;
      if (len < 1) len = 1;
      if (len > MAX_SERIES_LENGTH_DEF) len = MAX_SERIES_LENGTH_DEF;
      if (cnt < 1) cnt = 1;
      if (cnt > MAX_SEGMENTS_DEF) cnt = MAX_SEGMENTS_DEF;
      if (cnt > len) cnt = len;
      seg_sum = 0;
      seg_fill = 0;
      seg_pos = 0;
      samples_left = len;
      segs_left = cnt;
      seg_len = len / cnt;
   endfunction

   function automatic logic [SYMBOL_W-1:0] band_of(longint sum, int unsigned len);
      int unsigned a;
      logic [SYMBOL_W-1:0] band;
      longint scaled;
      a = cfg_alphabet;
      if (a < ALPHA_MIN) a = ALPHA_MIN;
      if (a > ALPHA_MAX) a = ALPHA_MAX;
      band = '0;
      scaled = longint'(len) << FRAC_BITS_DEF;
      for (int i = 0; i < a - 1; i++) begin
         if (longint'($signed(NORMAL_CUTS[3'(a - 2)][3'(i)])) * scaled <= sum * 100) band++;
      end
      return band;
   endfunction

   function automatic void predict_csr(logic [CSR_INDEX_W-1:0] idx,
                                       logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ALPHABET_SIZE: cfg_alphabet = data[ALPHA_W-1:0];
         CSR_SEGMENT_COUNT: begin
            cfg_segments = data[SEG_COUNT_W-1:0];
            restart_series();
         end
         CSR_SERIES_LENGTH: begin
            cfg_length = data[SERIES_LEN_W-1:0];
            restart_series();
         end
         default: ;
      endcase
   endfunction

   function automatic bit predict_sample(input logic signed [SAMPLE_W-1:0] value,
                                         output symbol_rec_type rec);
      rec = '0;
      seg_sum += value;
      seg_fill++;
      if (seg_fill < seg_len) return 1'b0;
      rec.symbol = band_of(seg_sum, seg_len);
      rec.segment_index = seg_pos[SEG_INDEX_W-1:0];
      rec.last = (segs_left <= 1);
      if (rec.last) begin
         restart_series();
      end else begin
         samples_left -= seg_len;
         segs_left--;
         seg_len = samples_left / segs_left;
         seg_pos++;
         seg_sum = 0;
         seg_fill = 0;
      end
      return 1'b1;
   endfunction

   function automatic probe_row_type csr_row(logic [CSR_INDEX_W-1:0] idx,
                                             logic [CSR_DATA_W-1:0] value);
      probe_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.csr = idx;
      row.value = value;
      return row;
   endfunction

   function automatic probe_row_type sample_row(logic signed [SAMPLE_W-1:0] value);
      probe_row_type row;
      row = '0;
      row.kind = ROW_SAMPLE;
      row.sample = value;
      return row;
   endfunction

   function automatic probe_row_type known_row(logic signed [SAMPLE_W-1:0] value,
                                               int sym, int idx, bit last);
      probe_row_type row;
      row = sample_row(value);
      row.typed = 1'b1;
      row.want.symbol = SYMBOL_W'(sym);
      row.want.segment_index = SEG_INDEX_W'(idx);
      row.want.last = last;
      return row;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      int v;
      if ($urandom_range(0, 7) == 0) sample_level = int'($urandom_range(0, 14000)) - 7000;
      case ($urandom_range(0, 9))
         0: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         1, 2: v = int'($urandom_range(0, 65535)) - 32768;
         default: v = sample_level + int'($urandom_range(0, 4000)) - 2000;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input bit typed,
                              input symbol_rec_type known);
      symbol_rec_type got;
      symbol_rec_type entry;
      while (!steady_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (predict_sample(value, got)) begin
         entry = typed ? known : got;
         pending_symbols = {pending_symbols, entry};
      end
   endtask

   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      predict_csr(idx, data);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : symbol_sink
      symbol_rec_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_symbols.size() == 0) begin
               $error("symbol transaction with no expectation: symbol %0d segment_index %0d",
                      rsp_bus.symbol, rsp_bus.segment_index);
               failures++;
            end else begin
               want = pending_symbols.pop_front();
               if (rsp_bus.symbol !== want.symbol) begin
                  $error("symbol: expected %0d, got %0d", want.symbol, rsp_bus.symbol);
                  failures++;
               end
               if (rsp_bus.segment_index !== want.segment_index) begin
                  $error("segment_index: expected %0d, got %0d",
                         want.segment_index, rsp_bus.segment_index);
                  failures++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
                  failures++;
               end
            end
            symbols_seen++;
         end
         if (!long_stall_done && symbols_seen == STALL_AT) begin
            rsp_bus.ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            long_stall_done = 1'b1;
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] len;
      logic [CSR_DATA_W-1:0] cnt;
      logic [CSR_DATA_W-1:0] alpha;
      int burst;
      int phase;
      int random_sent;
      req_bus.valid <= 1'b0;
      req_bus.sample <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_ALPHABET_SIZE;
      csr_wdata <= '0;
      cfg_alphabet = ALPHA_RESET;
      cfg_segments = SEG_COUNT_RESET;
      cfg_length = SERIES_LEN_RESET;
      restart_series();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      probe_rows = {
         csr_row(CSR_SERIES_LENGTH, 13'd1),
         csr_row(CSR_SEGMENT_COUNT, 13'd1),
         csr_row(CSR_ALPHABET_SIZE, 13'd5),
         csr_row(CSR_NO_REGISTER, 13'h1FFF),
         known_row(16'sd1024, 3, 0, 1'b1),
         known_row(16'sd1023, 2, 0, 1'b1),
         known_row(-16'sd1024, 2, 0, 1'b1),
         known_row(-16'sd1025, 1, 0, 1'b1),
         known_row(16'sd32767, 4, 0, 1'b1),
         known_row(-16'sd32768, 0, 0, 1'b1),
         csr_row(CSR_ALPHABET_SIZE, 13'd0),
         known_row(16'sd0, 1, 0, 1'b1),
         known_row(-16'sd1, 0, 0, 1'b1),
         csr_row(CSR_ALPHABET_SIZE, 13'd15),
         known_row(16'sd32767, 8, 0, 1'b1),
         known_row(-16'sd32768, 0, 0, 1'b1),
         csr_row(CSR_SERIES_LENGTH, 13'd0),
         csr_row(CSR_SEGMENT_COUNT, 13'd0),
         sample_row(16'sd5),
         csr_row(CSR_ALPHABET_SIZE, 13'd4),
         csr_row(CSR_SERIES_LENGTH, 13'd5),
         csr_row(CSR_SEGMENT_COUNT, 13'd3),
         sample_row(16'sd100),
         sample_row(16'sd200),
         sample_row(-16'sd300),
         sample_row(16'sd7),
         sample_row(16'sd8),
         csr_row(CSR_SERIES_LENGTH, 13'd3),
         csr_row(CSR_SEGMENT_COUNT, 13'd1),
         sample_row(16'sd1000),
         csr_row(CSR_SEGMENT_COUNT, 13'd7),
         sample_row(16'sd4096),
         sample_row(-16'sd4096),
         sample_row(16'sd0)
      };

      foreach (probe_rows[r]) begin
         if (probe_rows[r].kind == ROW_CSR) begin
            settle_block();
            write_csr(probe_rows[r].csr, probe_rows[r].value);
         end else begin
            push_sample(probe_rows[r].sample, probe_rows[r].typed, probe_rows[r].want);
         end
      end

      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               len = 13'd256;
               cnt = 13'd256;
               alpha = 13'd9;
               burst = 256;
            end
            1: begin
               len = 13'd8191;
               cnt = 13'd511;
               alpha = 13'd2;
               burst = 48;
            end
            2: begin
               len = 13'd8191;
               cnt = 13'd1;
               alpha = 13'd1;
               burst = 20;
            end
            default: begin
               len = CSR_DATA_W'($urandom_range(1, 40));
               if ($urandom_range(0, 9) == 0) cnt = CSR_DATA_W'($urandom_range(257, 511));
               else cnt = CSR_DATA_W'($urandom_range(0, len + 2));
               alpha = CSR_DATA_W'($urandom_range(0, 15));
               burst = (phase == 3) ? 160 : $urandom_range(len, 4 * len + 8);
            end
         endcase
         if (burst > RANDOM_ITEMS - random_sent) burst = RANDOM_ITEMS - random_sent;
         settle_block();
         steady_stretch = (phase == 3);
         write_csr(CSR_ALPHABET_SIZE, alpha);
         write_csr(CSR_SEGMENT_COUNT, cnt);
         write_csr(CSR_SERIES_LENGTH, len);
         repeat (burst) begin
            push_sample(draw_sample(), 1'b0, '0);
            random_sent++;
         end
         phase++;
      end

      settle_block();
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
